>>> rtl/assert_macros.svh
// Assertion macros used by the RTL file cdq_ctrl.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock with an active-low reset.
`define ASSERT_CLK(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: assertion failed");

// Concurrent assertion on the usual clock and reset of a module.
`define ASSERT(name, prop) `ASSERT_CLK(name, clk_i, rst_ni, prop)

`endif

>>> rtl/cdq_pkg.sv
package cdq_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned OpW    = 2;
  localparam int unsigned CountW = 5;

  localparam logic [CountW-1:0] CapReset = 5'd16;

  typedef logic signed [WordW-1:0] word_t;
  typedef logic [CountW-1:0]       count_t;

  typedef enum logic [OpW-1:0] {
    OpPushFront = 2'd0,
    OpPushBack  = 2'd1,
    OpPopFront  = 2'd2,
    OpPopBack   = 2'd3
  } cdq_op_e;

  typedef enum logic [1:0] {
    StIdle = 2'd0,
    StRead = 2'd1,
    StResp = 2'd2
  } cdq_state_e;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } cdq_mem_ctl_t;

  typedef struct packed {
    logic   op_ok;
    logic   is_empty;
    logic   is_full;
    count_t item_count;
  } cdq_status_t;

endpackage

>>> rtl/cdq_if.sv
interface cdq_req_if;
  import cdq_pkg::*;

  logic              valid;
  logic              ready;
  logic [OpW-1:0]    operation;
  word_t             push_value;

  modport source (output valid, output operation, output push_value, input ready);
  modport sink   (input valid, input operation, input push_value, output ready);
endinterface

interface cdq_rsp_if;
  import cdq_pkg::*;

  logic   valid;
  logic   ready;
  logic   op_ok;
  word_t  front_item;
  word_t  rear_item;
  logic   is_empty;
  logic   is_full;
  count_t item_count;

  modport source (output valid, output op_ok, output front_item, output rear_item,
                  output is_empty, output is_full, output item_count, input ready);
  modport sink   (input valid, input op_ok, input front_item, input rear_item,
                  input is_empty, input is_full, input item_count, output ready);
endinterface

>>> rtl/cdq_store.sv
module cdq_store #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned PtrW  = 4
) (
  input  logic                 clk_i,
  input  cdq_pkg::cdq_mem_ctl_t ctl_i,
  input  logic [PtrW-1:0]      waddr_i,
  input  cdq_pkg::word_t       wdata_i,
  input  logic [PtrW-1:0]      raddr_front_i,
  input  logic [PtrW-1:0]      raddr_rear_i,
  output cdq_pkg::word_t       rdata_front_o,
  output cdq_pkg::word_t       rdata_rear_o
);
  import cdq_pkg::*;

  word_t mem [DEPTH];
  word_t rdata_front_q;
  word_t rdata_rear_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rdata_front_q <= mem[raddr_front_i];
      rdata_rear_q  <= mem[raddr_rear_i];
    end
  end

  assign rdata_front_o = rdata_front_q;
  assign rdata_rear_o  = rdata_rear_q;

endmodule

>>> rtl/cdq_ctrl.sv
`include "assert_macros.svh"

module cdq_ctrl #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned PtrW  = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  cdq_pkg::count_t        cfg_wdata_i,
  input  logic                   in_valid_i,
  input  logic [cdq_pkg::OpW-1:0] in_op_i,
  output logic                   in_ready_o,
  input  logic                   out_free_i,
  output logic                   load_o,
  output cdq_pkg::cdq_status_t   status_o,
  output cdq_pkg::cdq_mem_ctl_t  mem_ctl_o,
  output logic [PtrW-1:0]        waddr_o,
  output logic [PtrW-1:0]        raddr_front_o,
  output logic [PtrW-1:0]        raddr_rear_o
);
  import cdq_pkg::*;

  localparam int unsigned DepthCap = (DEPTH > 31) ? 31 : DEPTH;
  localparam count_t          DepthCount = CountW'(DepthCap);
  localparam logic [PtrW-1:0] LastIdx    = PtrW'(DEPTH - 1);
  localparam logic [PtrW:0]   DepthWide  = (PtrW + 1)'(DEPTH);

  cdq_state_e      state_q, state_d;
  logic [PtrW-1:0] head_q, head_d;
  logic [PtrW-1:0] tail_q, tail_d;
  count_t          count_q, count_d;
  count_t          cap_q;
  logic            ok_q, ok_d;
  count_t          eff_cap;
  logic            is_full;
  logic            is_empty;
  logic            in_fire;
  logic [PtrW-1:0] head_prev;
  logic [PtrW-1:0] head_next;
  logic [PtrW-1:0] tail_prev;
  logic [PtrW-1:0] tail_next;

  assign eff_cap  = (cap_q > DepthCount) ? DepthCount : cap_q;
  assign is_full  = count_q >= eff_cap;
  assign is_empty = count_q == '0;

  assign head_prev = (head_q == '0) ? LastIdx : head_q - 1'b1;
  assign head_next = (head_q == LastIdx) ? '0 : head_q + 1'b1;
  assign tail_prev = (tail_q == '0) ? LastIdx : tail_q - 1'b1;
  assign tail_next = (tail_q == LastIdx) ? '0 : tail_q + 1'b1;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_fire) state_d = StRead;
      end
      StRead: begin
        state_d = StResp;
      end
      StResp: begin
        if (out_free_i) state_d = in_fire ? StRead : StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    load_o     = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
      end
      StResp: begin
        in_ready_o = out_free_i;
        load_o     = out_free_i;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  assign in_fire = in_valid_i && in_ready_o;

  always_comb begin
    head_d            = head_q;
    tail_d            = tail_q;
    count_d           = count_q;
    ok_d              = ok_q;
    mem_ctl_o.wr_en   = 1'b0;
    mem_ctl_o.rd_en   = state_q == StRead;
    waddr_o           = tail_q;
    if (in_fire) begin
      ok_d = 1'b0;
      unique case (cdq_op_e'(in_op_i))
        OpPushFront: begin
          waddr_o = head_prev;
          if (!is_full) begin
            head_d          = head_prev;
            count_d         = count_q + 1'b1;
            mem_ctl_o.wr_en = 1'b1;
            ok_d            = 1'b1;
          end
        end
        OpPushBack: begin
          if (!is_full) begin
            tail_d          = tail_next;
            count_d         = count_q + 1'b1;
            mem_ctl_o.wr_en = 1'b1;
            ok_d            = 1'b1;
          end
        end
        OpPopFront: begin
          if (!is_empty) begin
            head_d  = head_next;
            count_d = count_q - 1'b1;
            ok_d    = 1'b1;
          end
        end
        OpPopBack: begin
          if (!is_empty) begin
            tail_d  = tail_prev;
            count_d = count_q - 1'b1;
            ok_d    = 1'b1;
          end
        end
        default: begin
          ok_d = 1'b0;
        end
      endcase
    end
  end

  assign raddr_front_o   = head_q;
  assign raddr_rear_o    = tail_prev;

  assign status_o.op_ok      = ok_q;
  assign status_o.is_empty   = is_empty;
  assign status_o.is_full    = is_full;
  assign status_o.item_count = count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      cap_q   <= CapReset;
      ok_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      ok_q    <= ok_d;
      if (cfg_we_i) cap_q <= cfg_wdata_i;
    end
  end

  logic [PtrW:0] ring_sum;
  logic [PtrW:0] ring_tail;

  assign ring_sum  = {1'b0, head_q} + (PtrW + 1)'(count_q);
  assign ring_tail = (ring_sum >= DepthWide) ? ring_sum - DepthWide : ring_sum;

  `ASSERT(a_count_bound, 32'(count_q) <= DEPTH)
  `ASSERT(a_ring_consistent, ring_tail == {1'b0, tail_q})
  `ASSERT(a_no_early_result, in_fire |=> !load_o)
  `ASSERT(a_read_after_accept, mem_ctl_o.rd_en |-> $past(in_fire))

endmodule

>>> rtl/circular_double_ended_queue.sv
// Bounded double-ended queue of 32-bit words held in a ring memory.
// Request channel (req): each word carries an operation (push front, push
// back, pop front, pop back) and a value that only pushes store.
// Response channel (rsp): one word per request with the success flag and,
// after the operation, the front and rear words, the empty and full flags
// and the item count. Front and rear read as all ones when the queue is empty.
// Configuration: cfg_we_i writes cfg_wdata_i as the capacity in use, clamped
// to DEPTH or 31, whichever is less; write it only while the block is idle.
// A push writes the ring memory when the request is accepted; the read state
// then reads it (reads are registered) and the response state loads the output
// register, where the next request may be accepted, but not in the read state.
// Reset clears the pointers and the count and sets the capacity to 16; the
// memory is not cleared, since only occupied entries are shown.
// When the receiver stalls, the response is held in the output register and
// the next request is still accepted and processed up to the memory read;
// it then waits until the output register is free.
module circular_double_ended_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  cdq_pkg::count_t     cfg_wdata_i,
  cdq_req_if.sink             req,
  cdq_rsp_if.source           rsp
);
  import cdq_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cdq_mem_ctl_t    mem_ctl;
  cdq_status_t     status;
  logic [PtrW-1:0] waddr;
  logic [PtrW-1:0] raddr_front;
  logic [PtrW-1:0] raddr_rear;
  word_t           rdata_front;
  word_t           rdata_rear;
  logic            load;
  logic            out_free;
  logic            out_valid_q, out_valid_d;
  cdq_status_t     out_status_q;
  word_t           out_front_q;
  word_t           out_rear_q;

  cdq_ctrl #(
    .DEPTH(DEPTH),
    .PtrW (PtrW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (req.valid),
    .in_op_i      (req.operation),
    .in_ready_o   (req.ready),
    .out_free_i   (out_free),
    .load_o       (load),
    .status_o     (status),
    .mem_ctl_o    (mem_ctl),
    .waddr_o      (waddr),
    .raddr_front_o(raddr_front),
    .raddr_rear_o (raddr_rear)
  );

  cdq_store #(
    .DEPTH(DEPTH),
    .PtrW (PtrW)
  ) u_store (
    .clk_i        (clk_i),
    .ctl_i        (mem_ctl),
    .waddr_i      (waddr),
    .wdata_i      (req.push_value),
    .raddr_front_i(raddr_front),
    .raddr_rear_i (raddr_rear),
    .rdata_front_o(rdata_front),
    .rdata_rear_o (rdata_rear)
  );

  assign out_free = !out_valid_q || rsp.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (rsp.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_status_q <= status;
      out_front_q  <= status.is_empty ? '1 : rdata_front;
      out_rear_q   <= status.is_empty ? '1 : rdata_rear;
    end
  end

  assign rsp.valid      = out_valid_q;
  assign rsp.op_ok      = out_status_q.op_ok;
  assign rsp.front_item = out_front_q;
  assign rsp.rear_item  = out_rear_q;
  assign rsp.is_empty   = out_status_q.is_empty;
  assign rsp.is_full    = out_status_q.is_full;
  assign rsp.item_count = out_status_q.item_count;

endmodule

>>> verif/cdq_deque_checker.sv
module cdq_deque_checker (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  cdq_pkg::count_t cfg_wdata_i,
  cdq_req_if              req,
  cdq_rsp_if              rsp,
  output int unsigned     errors_o,
  output int unsigned     awaited_o
);
  import cdq_pkg::*;

  localparam int unsigned Depth = 16;

  typedef struct packed {
    logic   op_ok;
    word_t  front_item;
    word_t  rear_item;
    logic   is_empty;
    logic   is_full;
    count_t item_count;
  } deque_reply_t;

  word_t        slots [Depth];
  logic [3:0]   front_idx;
  logic [3:0]   back_idx;
  count_t       held;
  count_t       capacity;
  deque_reply_t replies_due [$];

  function automatic deque_reply_t apply_op(cdq_op_e op, word_t value);
    deque_reply_t r;
    count_t       limit;
    logic         ok;
    limit = (capacity > count_t'(Depth)) ? count_t'(Depth) : capacity;
    ok = 1'b0;
    case (op)
      OpPushFront: begin
        if (held < limit) begin
          front_idx = front_idx - 4'd1;
          slots[front_idx] = value;
          held = held + 1'b1;
          ok = 1'b1;
        end
      end
      OpPushBack: begin
        if (held < limit) begin
          slots[back_idx] = value;
          back_idx = back_idx + 4'd1;
          held = held + 1'b1;
          ok = 1'b1;
        end
      end
      OpPopFront: begin
        if (held != '0) begin
          front_idx = front_idx + 4'd1;
          held = held - 1'b1;
          ok = 1'b1;
        end
      end
      default: begin
        if (held != '0) begin
          back_idx = back_idx - 4'd1;
          held = held - 1'b1;
          ok = 1'b1;
        end
      end
    endcase
    r.op_ok      = ok;
    r.is_empty   = (held == '0);
    r.is_full    = (held >= limit);
    r.item_count = held;
    r.front_item = r.is_empty ? '1 : slots[front_idx];
    r.rear_item  = r.is_empty ? '1 : slots[back_idx - 4'd1];
    return r;
  endfunction

  task automatic report(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    errors_o++;
  endtask

  task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      report($sformatf("%s got %h expected %h", name, got, want));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    deque_reply_t want;
    if (!rst_ni) begin
      front_idx = '0;
      back_idx  = '0;
      held      = '0;
      capacity  = CapReset;
      replies_due.delete();
      awaited_o = 0;
    end else begin
      if (cfg_we_i) begin
        capacity = cfg_wdata_i;
      end
      if (rsp.valid && rsp.ready) begin
        if (replies_due.size() == 0) begin
          report("response word arrived with none outstanding");
        end else begin
          want = replies_due.pop_front();
          compare_field("op_ok", rsp.op_ok, want.op_ok);
          compare_field("front_item", rsp.front_item, want.front_item);
          compare_field("rear_item", rsp.rear_item, want.rear_item);
          compare_field("is_empty", rsp.is_empty, want.is_empty);
          compare_field("is_full", rsp.is_full, want.is_full);
          compare_field("item_count", rsp.item_count, want.item_count);
        end
      end
      if (req.valid && req.ready) begin
        replies_due.push_back(apply_op(cdq_op_e'(req.operation), req.push_value));
      end
      awaited_o = replies_due.size();
    end
  end

  initial errors_o = 0;

endmodule

>>> verif/tb.sv
module tb;
  import cdq_pkg::*;

  localparam int unsigned QuietLimit     = 2000;
  localparam int unsigned RandomPerPhase = 45;
  localparam int unsigned PhaseCount     = 9;
  localparam count_t      CapPlan [PhaseCount] =
    '{5'd31, 5'd1, 5'd7, 5'd16, 5'd0, 5'd3, 5'd17, 5'd2, 5'd16};

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we;
  count_t      cfg_wdata;
  int unsigned src_idle;
  int unsigned snk_idle;
  int unsigned quiet_cycles;
  int unsigned chk_errors;
  int unsigned awaited;

  cdq_req_if req_ch ();
  cdq_rsp_if rsp_ch ();

  always #10 clk_i = ~clk_i;

  circular_double_ended_queue dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req         (req_ch),
    .rsp         (rsp_ch)
  );

  cdq_deque_checker chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .errors_o    (chk_errors),
    .awaited_o   (awaited)
  );

  always @(posedge clk_i) begin
    rsp_ch.ready <= ($urandom_range(0, 99) >= snk_idle);
  end

  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic word_t pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return '0;
      3:       return '1;
      default: return word_t'($urandom());
    endcase
  endfunction

  task automatic send_word(cdq_op_e op, word_t value);
    while ($urandom_range(0, 99) < src_idle) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid      <= 1'b1;
    req_ch.operation  <= op;
    req_ch.push_value <= value;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
  endtask

  task automatic await_quiet();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    wait (awaited == 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_capacity(count_t cap);
    await_quiet();
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    logic        filling;
    logic        push;
    cdq_op_e     op;
    int unsigned roll;

    rst_ni            = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    quiet_cycles      = 0;
    src_idle          = 29;
    snk_idle          = 71;
    req_ch.valid      = 1'b0;
    req_ch.operation  = OpPushFront;
    req_ch.push_value = '0;
    rsp_ch.ready      = 1'b0;
    filling           = 1'b1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Pops on an empty deque, then pushes at both ends; the front index wraps.
    send_word(OpPopFront, pick_value());
    send_word(OpPopBack, pick_value());
    send_word(OpPushFront, 32'sh8000_0000);
    send_word(OpPushBack, 32'sh7FFF_FFFF);
    send_word(OpPushFront, '1);
    send_word(OpPushBack, '0);
    send_word(OpPushFront, 32'shAAAA_AAAA);
    send_word(OpPushBack, 32'sh5555_5555);
    send_word(OpPopFront, pick_value());
    send_word(OpPopBack, pick_value());

    // Capacity lowered below the number of words held.
    set_capacity(5'd3);
    send_word(OpPushBack, pick_value());
    send_word(OpPopFront, pick_value());
    send_word(OpPushFront, pick_value());
    send_word(OpPopBack, pick_value());
    send_word(OpPushFront, pick_value());

    // A capacity of zero makes the deque both empty and full once drained.
    set_capacity(5'd0);
    send_word(OpPushFront, pick_value());
    send_word(OpPushBack, pick_value());
    send_word(OpPopFront, pick_value());
    send_word(OpPopFront, pick_value());
    send_word(OpPopFront, pick_value());
    send_word(OpPushBack, pick_value());

    for (int p = 0; p < PhaseCount; p++) begin
      if (p == 3) begin
        src_idle = 71;
        snk_idle = 29;
      end else if (p == 6) begin
        src_idle = 0;
        snk_idle = 0;
      end
      set_capacity(CapPlan[p]);
      for (int n = 0; n < RandomPerPhase; n++) begin
        if ($urandom_range(0, 11) == 0) begin
          filling = !filling;
        end
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
          op = cdq_op_e'($urandom_range(0, 3));
        end else begin
          push = filling ? (roll < 80) : (roll < 30);
          if (push) begin
            op = $urandom_range(0, 1) ? OpPushBack : OpPushFront;
          end else begin
            op = $urandom_range(0, 1) ? OpPopBack : OpPopFront;
          end
        end
        send_word(op, pick_value());
      end
    end

    await_quiet();
    repeat (8) @(posedge clk_i);
    if (chk_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
